// ----- rtl/frame_timestamp_snap_search_macros.svh -----
// Assertion macros for the frame timestamp snap search checker.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef FRAME_TIMESTAMP_SNAP_SEARCH_MACROS_SVH
`define FRAME_TIMESTAMP_SNAP_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FTSS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FTSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ftss_pkg.sv -----
// Shared constants and codes for the frame timestamp snap search block.
// No dependencies; frame_timestamp_snap_search and the checker import it.
`default_nettype none

package ftss_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int TIME_BITS     = 48;
    localparam int ENTRY_W       = TIME_BITS - 1;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int INDEX_W       = 10;
    localparam int COUNT_W       = 11;
    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 4;
    localparam int REG_ADDR_LSB  = 3;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        REG_ASSET_DURATION = 1'b0,
        REG_FRAME_COUNT    = 1'b1
    } reg_index_t;

endpackage

`default_nettype wire

// ----- rtl/ftss_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module ftss_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/frame_timestamp_snap_search.sv -----
// Frame timestamp table with snap and search queries. A write word (op = write) stores
// one timestamp. A query word runs two halving searches side by side, one upper bound on
// the time and one lower bound on the clamped time, each on its own copy of the table in
// a RAM with registered read data, one probe per cycle. A query passes through setup, the
// probes, a fetch of the neighbor entries and the indexed entry, two states that form the
// result (prep and done), and the idle state that takes the next word. The result sits in
// an output register, so the next word is taken while it waits. Configuration over APB at
// byte addresses 0 (asset_duration) and 8 (frame_count); the user must see that they are
// written only while the block is idle, and the block itself does not enforce this.
// Depends on ftss_pkg and ftss_ram.
`default_nettype none

module frame_timestamp_snap_search import ftss_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,

    input  logic                        query_valid,
    output logic                        query_ready,
    input  logic                        op,
    input  logic [INDEX_W-1:0]          entry_index,
    input  logic signed [TIME_BITS-1:0] query_time,
    input  logic signed [TIME_BITS-1:0] range_length,

    output logic                        result_valid,
    input  logic                        result_ready,
    output logic                        before_valid,
    output logic [INDEX_W-1:0]          before_index,
    output logic [ENTRY_W-1:0]          nearest_time,
    output logic                        previous_valid,
    output logic [ENTRY_W-1:0]          previous_time,
    output logic                        next_valid,
    output logic [ENTRY_W-1:0]          next_time,
    output logic                        index_time_valid,
    output logic [ENTRY_W-1:0]          index_time,
    output logic                        range_inside
);

    localparam int ENG_LOWER = 0;
    localparam int ENG_UPPER = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_FETCH,
        ST_PREP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               before_valid;
        logic [INDEX_W-1:0] before_index;
        logic [ENTRY_W-1:0] nearest_time;
        logic               previous_valid;
        logic [ENTRY_W-1:0] previous_time;
        logic               next_valid;
        logic [ENTRY_W-1:0] next_time;
        logic               index_time_valid;
        logic [ENTRY_W-1:0] index_time;
        logic               range_inside;
    } result_t;

    state_t                     state_reg;
    logic [ENTRY_W-1:0]         duration_reg;
    logic [COUNT_W-1:0]         frame_count_reg;
    logic                       res_valid_reg;
    result_t                    res_reg;

    // Query word and its precomputed compares
    logic signed [TIME_BITS-1:0] t_reg;
    logic signed [TIME_BITS-1:0] len_reg;
    logic [INDEX_W-1:0]          idx_reg;
    logic [ENTRY_W-1:0]          key_reg;
    logic [CNT_W-1:0]            n_reg;
    logic                        t_neg_reg;
    logic                        t_pos_reg;
    logic                        t_lt_dur_reg;

    // Search engines: lower bound on key_reg, upper bound on t_reg
    logic [CNT_W-1:0]            lo_reg     [2];
    logic [CNT_W-1:0]            span_reg   [2];
    logic [1:0]                  pend_reg;
    logic [CNT_W-1:0]            lo_next    [2];
    logic [CNT_W-1:0]            span_next  [2];
    logic [1:0]                  pend_next;
    logic [CNT_W-1:0]            half       [2];
    logic [CNT_W-1:0]            mid        [2];
    logic [CNT_W-1:0]            probe_addr [2];
    logic signed [TIME_BITS-1:0] probe      [2];
    logic [1:0]                  go_up;

    logic [ADDR_W-1:0]           rd_addr [2];
    logic [ENTRY_W-1:0]          ram_rd  [2];
    logic                        wr_en;

    logic [ENTRY_W-1:0]          at_l_reg;
    logic [ENTRY_W-1:0]          at_u_reg;

    result_t                     stage_reg;
    logic [ENTRY_W-1:0]          near_pv_reg;
    logic [ENTRY_W-1:0]          near_nx_reg;
    logic signed [TIME_BITS-1:0] d_prev_reg;
    logic signed [TIME_BITS-1:0] d_next_reg;
    logic                        near_snap_reg;

    logic                        cfg_write;
    reg_index_t                  cfg_index;
    logic                        accept;
    logic signed [TIME_BITS-1:0] dur_s;
    logic [CNT_W-1:0]            n_in;
    logic [ENTRY_W-1:0]          key_in;

    logic                        kl_lt_n;
    logic                        ku_lt_n;
    logic [ENTRY_W-1:0]          prep_pv;
    logic [ENTRY_W-1:0]          prep_nx;
    logic                        prep_hit;
    logic signed [TIME_BITS-1:0] prep_remain;
    result_t                     prep_stage;
    result_t                     res_load;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[REG_ADDR_LSB]);

    always_comb
    begin
        unique case (cfg_index)
            REG_ASSET_DURATION: prdata = APB_DATA_W'(duration_reg);
            REG_FRAME_COUNT:    prdata = APB_DATA_W'(frame_count_reg);
        endcase
    end

    // Input side
    assign query_ready = (state_reg == ST_IDLE);
    assign accept      = query_valid && query_ready;
    assign wr_en       = accept && (op == OP_WRITE)
                         && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign dur_s       = $signed({1'b0, duration_reg});

    always_comb
    begin
        if (32'(frame_count_reg) > 32'(TABLE_DEPTH))
        begin
            n_in = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_in = CNT_W'(frame_count_reg);
        end

        // Clamp the time to 0..duration
        if (query_time[TIME_BITS-1])
        begin
            key_in = '0;
        end
        else if (query_time > dur_s)
        begin
            key_in = duration_reg;
        end
        else
        begin
            key_in = query_time[ENTRY_W-1:0];
        end
    end

    // One probe per engine per cycle: the data of the last probe decides the next one
    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            half[e]  = span_reg[e] >> 1;
            mid[e]   = lo_reg[e] + half[e];
            probe[e] = $signed({1'b0, ram_rd[e]});
            if (e == ENG_LOWER)
            begin
                go_up[e] = probe[e] < $signed({1'b0, key_reg});
            end
            else
            begin
                go_up[e] = probe[e] <= t_reg;
            end

            lo_next[e]   = lo_reg[e];
            span_next[e] = span_reg[e];
            if (pend_reg[e])
            begin
                if (go_up[e])
                begin
                    lo_next[e]   = mid[e] + CNT_W'(1);
                    span_next[e] = span_reg[e] - half[e] - CNT_W'(1);
                end
                else
                begin
                    span_next[e] = half[e];
                end
            end
            pend_next[e]  = (span_next[e] != '0);
            // A finished engine keeps probing its bound, so its entry is read for free
            probe_addr[e] = lo_next[e] + (span_next[e] >> 1);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_START:
            begin
                rd_addr[ENG_LOWER] = ADDR_W'(n_reg >> 1);
                rd_addr[ENG_UPPER] = ADDR_W'(n_reg >> 1);
            end
            ST_SEARCH:
            begin
                rd_addr[ENG_LOWER] = ADDR_W'(probe_addr[ENG_LOWER]);
                rd_addr[ENG_UPPER] = ADDR_W'(probe_addr[ENG_UPPER]);
            end
            ST_FETCH:
            begin
                rd_addr[ENG_LOWER] = ADDR_W'(lo_reg[ENG_LOWER] - CNT_W'(1));
                rd_addr[ENG_UPPER] = ADDR_W'(idx_reg);
            end
            default:
            begin
                rd_addr[ENG_LOWER] = '0;
                rd_addr[ENG_UPPER] = '0;
            end
        endcase
    end

    ftss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_lower (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (query_time[ENTRY_W-1:0]),
        .rd_addr (rd_addr[ENG_LOWER]),
        .rd_data (ram_rd[ENG_LOWER])
    );

    ftss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_upper (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (query_time[ENTRY_W-1:0]),
        .rd_addr (rd_addr[ENG_UPPER]),
        .rd_data (ram_rd[ENG_UPPER])
    );

    // Result preparation: lower RAM holds entry k-1, upper RAM the indexed entry
    always_comb
    begin
        kl_lt_n  = lo_reg[ENG_LOWER] < n_reg;
        ku_lt_n  = lo_reg[ENG_UPPER] < n_reg;
        prep_pv  = (lo_reg[ENG_LOWER] != '0) ? ram_rd[ENG_LOWER] : '0;
        prep_nx  = kl_lt_n ? at_l_reg : duration_reg;
        prep_hit = kl_lt_n && (at_l_reg == key_reg);
        prep_remain = dur_s - t_reg;

        prep_stage = '0;
        if ((n_reg != '0) && !t_neg_reg && t_lt_dur_reg && (lo_reg[ENG_UPPER] != '0))
        begin
            prep_stage.before_valid = 1'b1;
            prep_stage.before_index = INDEX_W'(lo_reg[ENG_UPPER] - CNT_W'(1));
        end
        prep_stage.nearest_time = key_reg;
        if (t_pos_reg)
        begin
            prep_stage.previous_valid = 1'b1;
            prep_stage.previous_time  = prep_pv;
        end
        if (t_neg_reg)
        begin
            prep_stage.next_valid = 1'b1;
        end
        else if (t_lt_dur_reg)
        begin
            prep_stage.next_valid = 1'b1;
            prep_stage.next_time  = ku_lt_n ? at_u_reg : duration_reg;
        end
        if (32'(idx_reg) < 32'(n_reg))
        begin
            prep_stage.index_time_valid = 1'b1;
            prep_stage.index_time       = ram_rd[ENG_UPPER];
        end
        prep_stage.range_inside = !t_neg_reg && t_lt_dur_reg
                                  && !len_reg[TIME_BITS-1] && (len_reg != '0)
                                  && (len_reg <= prep_remain);
    end

    // Snap to the nearer neighbor; a tie goes to the earlier one
    always_comb
    begin
        res_load = stage_reg;
        if (near_snap_reg)
        begin
            res_load.nearest_time = (d_prev_reg <= d_next_reg) ? near_pv_reg : near_nx_reg;
        end
    end

    // Control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            duration_reg    <= ENTRY_W'(1);
            frame_count_reg <= '0;
            pend_reg        <= '0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ASSET_DURATION: duration_reg    <= pwdata[ENTRY_W-1:0];
                    REG_FRAME_COUNT:    frame_count_reg <= pwdata[COUNT_W-1:0];
                endcase
            end

            if ((state_reg == ST_DONE) && (!res_valid_reg || result_ready))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && result_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (op == OP_QUERY))
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    pend_reg  <= {2{n_reg != '0}};
                    state_reg <= ST_SEARCH;
                end
                ST_SEARCH:
                begin
                    pend_reg <= pend_next;
                    if (pend_next == '0)
                    begin
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // Hold until the output register is free
                    if (!res_valid_reg || result_ready)
                    begin
                        res_reg   <= res_load;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_QUERY))
        begin
            t_reg        <= query_time;
            len_reg      <= range_length;
            idx_reg      <= entry_index;
            key_reg      <= key_in;
            n_reg        <= n_in;
            t_neg_reg    <= query_time[TIME_BITS-1];
            t_pos_reg    <= !query_time[TIME_BITS-1] && (query_time != '0);
            t_lt_dur_reg <= query_time < dur_s;
        end

        unique case (state_reg)
            ST_START:
            begin
                for (int e = 0; e < 2; e++)
                begin
                    lo_reg[e]   <= '0;
                    span_reg[e] <= n_reg;
                end
            end
            ST_SEARCH:
            begin
                for (int e = 0; e < 2; e++)
                begin
                    lo_reg[e]   <= lo_next[e];
                    span_reg[e] <= span_next[e];
                end
            end
            ST_FETCH:
            begin
                at_l_reg <= ram_rd[ENG_LOWER];
                at_u_reg <= ram_rd[ENG_UPPER];
            end
            ST_PREP:
            begin
                stage_reg     <= prep_stage;
                near_pv_reg   <= prep_pv;
                near_nx_reg   <= prep_nx;
                d_prev_reg    <= $signed({1'b0, key_reg}) - $signed({1'b0, prep_pv});
                d_next_reg    <= $signed({1'b0, prep_nx}) - $signed({1'b0, key_reg});
                near_snap_reg <= (n_reg != '0) && (key_reg != duration_reg) && !prep_hit;
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid     = res_valid_reg;
    assign before_valid     = res_reg.before_valid;
    assign before_index     = res_reg.before_index;
    assign nearest_time     = res_reg.nearest_time;
    assign previous_valid   = res_reg.previous_valid;
    assign previous_time    = res_reg.previous_time;
    assign next_valid       = res_reg.next_valid;
    assign next_time        = res_reg.next_time;
    assign index_time_valid = res_reg.index_time_valid;
    assign index_time       = res_reg.index_time;
    assign range_inside     = res_reg.range_inside;

endmodule

`default_nettype wire

// ----- rtl/ftss_checker.sv -----
// Port-level checker for frame_timestamp_snap_search, attached by the bind below.
// Depends on ftss_pkg and frame_timestamp_snap_search_macros.svh.
`default_nettype none
`include "frame_timestamp_snap_search_macros.svh"

module ftss_checker import ftss_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               query_valid,
    input logic               query_ready,
    input logic               op,
    input logic               result_valid,
    input logic               result_ready,
    input logic               before_valid,
    input logic [INDEX_W-1:0] before_index,
    input logic [ENTRY_W-1:0] nearest_time,
    input logic               next_valid,
    input logic               range_inside
);

    // A query word keeps the block busy for at least the next cycle
    `FTSS_ASSERT_NEXT(a_query_busy, query_valid && query_ready && op == OP_QUERY, !query_ready, "query_ready high right after a query word")

    // A stalled result word holds
    `FTSS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(nearest_time) && $stable(before_index), "stalled result word changed")

    // A frame at or before the time means the time lies inside the asset
    `FTSS_ASSERT_IMPLY(a_before_has_next, result_valid && before_valid, next_valid, "before_valid without next_valid")

    // A range inside the asset starts inside it
    `FTSS_ASSERT_IMPLY(a_range_has_next, result_valid && range_inside, next_valid, "range_inside without next_valid")

endmodule

bind frame_timestamp_snap_search ftss_checker u_ftss_checker (.*);

`default_nettype wire
